>>> design/pcv_pkg.sv
package pcv_pkg;

  localparam logic [7:0] LENGTH_CAP_RESET = 8'd128;
  localparam logic [7:0] COUNT_MAX        = 8'd255;
  localparam logic [2:0] BASE_SAT         = 3'd5;
  localparam int         BASE_DEPTH       = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [23:0] NAME_CON = 24'h636F6E;
  localparam logic [23:0] NAME_PRN = 24'h70726E;
  localparam logic [23:0] NAME_AUX = 24'h617578;
  localparam logic [23:0] NAME_NUL = 24'h6E756C;
  localparam logic [23:0] NAME_COM = 24'h636F6D;
  localparam logic [23:0] NAME_LPT = 24'h6C7074;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_SUR = 8'hED;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;
  localparam logic [7:0] CONT_A0  = 8'hA0;
  localparam logic [7:0] CONT_9F  = 8'h9F;
  localparam logic [7:0] CONT_90  = 8'h90;
  localparam logic [7:0] CONT_8F  = 8'h8F;

  typedef enum logic [2:0] {
    RNG_ANY   = 3'd0,
    RNG_A0_BF = 3'd1,
    RNG_80_9F = 3'd2,
    RNG_90_BF = 3'd3,
    RNG_80_8F = 3'd4
  } cont_range_t;

  typedef struct packed {
    logic [1:0]  left;
    cont_range_t range;
  } utf8_state_t;

endpackage

>>> design/pcv_utf8.sv
module pcv_utf8 (
  input  pcv_pkg::utf8_state_t cur,
  input  logic [7:0]           data,
  output pcv_pkg::utf8_state_t nxt,
  output logic                 error
);
  import pcv_pkg::*;

  logic [7:0] lo;
  logic [7:0] hi;

  always_comb begin
    lo = CONT_LO;
    hi = CONT_HI;
    unique case (cur.range)
      RNG_ANY:   ;
      RNG_A0_BF: lo = CONT_A0;
      RNG_80_9F: hi = CONT_9F;
      RNG_90_BF: lo = CONT_90;
      RNG_80_8F: hi = CONT_8F;
      default:   ;
    endcase
  end

  always_comb begin
    nxt   = cur;
    error = 1'b0;
    if (cur.left != 2'd0) begin
      error     = (data < lo) || (data > hi);
      nxt.range = RNG_ANY;
      nxt.left  = cur.left - 2'd1;
    end else if (data <= CH_DEL) begin
      nxt = cur;
    end else if (data >= LEAD2_LO && data <= LEAD2_HI) begin
      nxt.left  = 2'd1;
      nxt.range = RNG_ANY;
    end else if (data >= LEAD3_LO && data <= LEAD3_HI) begin
      nxt.left  = 2'd2;
      nxt.range = (data == LEAD3_LO) ? RNG_A0_BF :
                  (data == LEAD3_SUR) ? RNG_80_9F : RNG_ANY;
    end else if (data >= LEAD4_LO && data <= LEAD4_HI) begin
      nxt.left  = 2'd3;
      nxt.range = (data == LEAD4_LO) ? RNG_90_BF :
                  (data == LEAD4_HI) ? RNG_80_8F : RNG_ANY;
    end else begin
      error = 1'b1;
    end
  end

endmodule

>>> design/path_component_validator.sv
// Channel   Handshake                    Payload
// item      item_valid / item_stall      has_byte, data_byte, last
// result    result_valid / result_stall  accepted, text_length
// config    cfg_we                       cfg_wdata (length cap)
//
// One request per cycle while item_stall is low; a result is registered when its last
// request leaves the input register. The rate is set by the single decode stage between
// the input register and the result register. rst is synchronous and clears the
// component state and sets the length cap to 128. item_stall rises only when a last
// request waits in the input register behind a result that is still stalled.
module path_component_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       has_byte,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       accepted,
  output logic [7:0] text_length
);
  import pcv_pkg::*;

  logic [7:0]  length_cap;

  logic        s1_valid;
  logic        s1_has;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        advance;

  utf8_state_t utf;
  utf8_state_t utf_next;
  utf8_state_t utf_dec;
  logic        utf_err;
  logic        reject;
  logic        reject_next;
  logic [7:0]  byte_count;
  logic [7:0]  byte_count_next;
  logic        ended;
  logic        ended_next;
  logic [7:0]  prev_byte;
  logic [7:0]  prev_byte_next;
  logic [7:0]  base_chars [BASE_DEPTH];
  logic [7:0]  base_chars_next [BASE_DEPTH];
  logic [2:0]  base_count;
  logic [2:0]  base_count_next;
  logic        dot_seen;
  logic        dot_seen_next;

  logic        take;
  logic [7:0]  low_byte;
  logic [23:0] base3;
  logic        reserved;
  logic        ok;

  assign item_stall = s1_valid && s1_last && result_valid && result_stall;
  assign advance    = s1_valid && !item_stall;
  assign take       = advance && s1_has && !ended && (s1_byte != 8'd0);
  assign low_byte   = (s1_byte >= CH_UP_A && s1_byte <= CH_UP_Z) ?
                      (s1_byte | CASE_BIT) : s1_byte;

  pcv_utf8 u_utf8 (
    .cur   (utf),
    .data  (s1_byte),
    .nxt   (utf_dec),
    .error (utf_err)
  );

  always_comb begin
    utf_next        = utf;
    reject_next     = reject;
    byte_count_next = byte_count;
    ended_next      = ended;
    prev_byte_next  = prev_byte;
    base_chars_next = base_chars;
    base_count_next = base_count;
    dot_seen_next   = dot_seen;
    if (advance && s1_has && !ended && (s1_byte == 8'd0)) begin
      ended_next = 1'b1;
    end
    if (take) begin
      if (byte_count != COUNT_MAX) begin
        byte_count_next = byte_count + 8'd1;
      end
      if (s1_byte < CH_SPACE || s1_byte == CH_DEL || s1_byte == CH_SLASH ||
          s1_byte == CH_BSL || s1_byte == CH_COLON || utf_err ||
          (s1_byte == CH_DOT && prev_byte == CH_DOT)) begin
        reject_next = 1'b1;
      end
      prev_byte_next = s1_byte;
      utf_next       = utf_dec;
      if (!dot_seen) begin
        if (s1_byte == CH_DOT) begin
          dot_seen_next = 1'b1;
        end else begin
          if (base_count < 3'(BASE_DEPTH)) begin
            base_chars_next[base_count[1:0]] = low_byte;
          end
          if (base_count < BASE_SAT) begin
            base_count_next = base_count + 3'd1;
          end
        end
      end
    end
  end

  assign base3 = {base_chars_next[0], base_chars_next[1], base_chars_next[2]};

  always_comb begin
    reserved = 1'b0;
    if (base_count_next == 3'd3) begin
      reserved = (base3 == NAME_CON) || (base3 == NAME_PRN) ||
                 (base3 == NAME_AUX) || (base3 == NAME_NUL);
    end else if (base_count_next == 3'd4) begin
      reserved = ((base3 == NAME_COM) || (base3 == NAME_LPT)) &&
                 (base_chars_next[3] >= CH_ONE) && (base_chars_next[3] <= CH_NINE);
    end
  end

  assign ok = !reject_next && (utf_next.left == 2'd0) && (byte_count_next != 8'd0) &&
              (byte_count_next < length_cap) && (prev_byte_next != CH_DOT) &&
              (prev_byte_next != CH_SPACE) && !reserved;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_cap <= LENGTH_CAP_RESET;
    end else if (cfg_we) begin
      length_cap <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      s1_has  <= has_byte;
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && s1_last)) begin
      utf        <= '{left: 2'd0, range: RNG_ANY};
      reject     <= 1'b0;
      byte_count <= 8'd0;
      ended      <= 1'b0;
      prev_byte  <= 8'd0;
      base_count <= 3'd0;
      dot_seen   <= 1'b0;
    end else begin
      utf        <= utf_next;
      reject     <= reject_next;
      byte_count <= byte_count_next;
      ended      <= ended_next;
      prev_byte  <= prev_byte_next;
      base_count <= base_count_next;
      dot_seen   <= dot_seen_next;
    end
    base_chars <= base_chars_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && s1_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && s1_last) begin
      accepted    <= ok;
      text_length <= byte_count_next;
    end
  end

endmodule

>>> dv/path_component_validator_test.sv
`timescale 1ns / 1ps

module path_component_validator_test;
  import pcv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [23:0] DEVICE_NAMES [6] =
    '{NAME_CON, NAME_PRN, NAME_AUX, NAME_NUL, NAME_COM, NAME_LPT};

  typedef struct {
    logic       accepted;
    logic [7:0] text_len;
  } verdict_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;
  typedef enum int {SHAPE_NAME, SHAPE_DEVICE, SHAPE_FAULT, SHAPE_NOISE} shape_t;
  typedef enum int {FAULT_UTF8, FAULT_CHAR, FAULT_DOTS, FAULT_ZERO} fault_t;
  typedef enum int {U8_GOOD, U8_BAD_CONT, U8_EDGE_CONT, U8_TRUNC, U8_STRAY} utf8_form_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic       has_byte = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       last = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       accepted;
  logic [7:0] text_length;

  // predictor state
  logic [7:0]  max_len = LENGTH_CAP_RESET;
  logic [1:0]  seq_left = '0;
  cont_range_t seq_range = RNG_ANY;
  logic        bad = 1'b0;
  logic [7:0]  n_bytes = '0;
  logic        ended = 1'b0;
  logic [7:0]  prev_ch = '0;
  logic [7:0]  stem [4] = '{default: '0};
  logic [2:0]  stem_len = '0;
  logic        dot_found = 1'b0;

  verdict_t   verdict_q [$];
  logic [7:0] name_bytes [$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         hold_requests = 0;
  int         holds_served = 0;
  int         hold_count = 0;
  int         cycle_count = 0;
  int         pattern_left = 0;
  rx_mode_t   rx_mode = RX_FREE;

  path_component_validator u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .has_byte     (has_byte),
    .data_byte    (data_byte),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted),
    .text_length  (text_length)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic predict_verdict(input logic h, input logic [7:0] b, input logic l);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  folded;
    logic [23:0] stem3;
    logic        reserved;
    verdict_t    v;
    if (h && !ended) begin
      if (b == 8'h00) begin
        ended = 1'b1;
      end else begin
        if (n_bytes != COUNT_MAX) n_bytes++;
        if (b < CH_SPACE || b == CH_DEL || b == CH_SLASH || b == CH_BSL || b == CH_COLON)
          bad = 1'b1;
        if (b == CH_DOT && prev_ch == CH_DOT) bad = 1'b1;
        prev_ch = b;
        if (!dot_found) begin
          if (b == CH_DOT) begin
            dot_found = 1'b1;
          end else begin
            folded = (b >= CH_UP_A && b <= CH_UP_Z) ? (b | CASE_BIT) : b;
            if (stem_len < 3'd4) stem[stem_len[1:0]] = folded;
            if (stem_len < BASE_SAT) stem_len++;
          end
        end
        if (seq_left != 2'd0) begin
          lo = CONT_LO;
          hi = CONT_HI;
          case (seq_range)
            RNG_A0_BF: lo = CONT_A0;
            RNG_80_9F: hi = CONT_9F;
            RNG_90_BF: lo = CONT_90;
            RNG_80_8F: hi = CONT_8F;
            default: ;
          endcase
          if (b < lo || b > hi) bad = 1'b1;
          seq_range = RNG_ANY;
          seq_left--;
        end else if (b > CH_DEL) begin
          if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            seq_left = 2'd1;
            seq_range = RNG_ANY;
          end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            seq_left = 2'd2;
            if (b == LEAD3_LO) seq_range = RNG_A0_BF;
            else if (b == LEAD3_SUR) seq_range = RNG_80_9F;
            else seq_range = RNG_ANY;
          end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            seq_left = 2'd3;
            if (b == LEAD4_LO) seq_range = RNG_90_BF;
            else if (b == LEAD4_HI) seq_range = RNG_80_8F;
            else seq_range = RNG_ANY;
          end else begin
            bad = 1'b1;
          end
        end
      end
    end
    if (l) begin
      stem3 = {stem[0], stem[1], stem[2]};
      reserved = (stem_len == 3'd3 && (stem3 == NAME_CON || stem3 == NAME_PRN ||
                                       stem3 == NAME_AUX || stem3 == NAME_NUL)) ||
                 (stem_len == 3'd4 && (stem3 == NAME_COM || stem3 == NAME_LPT) &&
                  stem[3] >= CH_ONE && stem[3] <= CH_NINE);
      v.accepted = !bad && seq_left == 2'd0 && n_bytes != 8'd0 && n_bytes < max_len &&
                   prev_ch != CH_DOT && prev_ch != CH_SPACE && !reserved;
      v.text_len = n_bytes;
      verdict_q = {verdict_q, v};
      seq_left = '0;
      seq_range = RNG_ANY;
      bad = 1'b0;
      n_bytes = '0;
      ended = 1'b0;
      prev_ch = '0;
      stem = '{default: '0};
      stem_len = '0;
      dot_found = 1'b0;
    end
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = verdict_q.pop_front();
          if (accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, want %b", accepted, want.accepted));
          if (text_length !== want.text_len)
            report_mismatch($sformatf("text_length %0d, want %0d", text_length,
                                      want.text_len));
        end
      end
      if (item_valid && !item_stall) predict_verdict(has_byte, data_byte, last);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (holds_served != hold_requests) begin
      result_stall <= 1'b1;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) begin
        hold_count = 0;
        holds_served = hold_requests;
      end
    end else begin
      if (pattern_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 128);
      end
      pattern_left--;
      case (rx_mode)
        RX_FREE:  result_stall <= 1'b0;
        RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
        default:  result_stall <= ~result_stall;
      endcase
    end
  end

  task automatic add_byte(input logic [7:0] b);
    name_bytes = {name_bytes, b};
  endtask

  task automatic send_item(input logic h, input logic [7:0] b, input logic l);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    has_byte <= h;
    data_byte <= b;
    last <= l;
    items_sent++;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_component();
    int k;
    bit split_end;
    split_end = ($urandom_range(0, 7) == 0);
    if (name_bytes.size() == 0) begin
      send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    end else begin
      for (k = 0; k < name_bytes.size(); k++) begin
        if ($urandom_range(0, 15) == 0) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        send_item(1'b1, name_bytes[k], !split_end && k == name_bytes.size() - 1);
      end
      if (split_end) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic await_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_length_cap(input logic [7:0] value);
    await_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    max_len = value;
  endtask

  task automatic put_utf8(input utf8_form_t form);
    int size;
    int k;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    size = $urandom_range(2, 4);
    lo = CONT_LO;
    hi = CONT_HI;
    if (size == 2) begin
      lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
    end else if (size == 3) begin
      lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
      if (lead == LEAD3_LO) lo = CONT_A0;
      if (lead == LEAD3_SUR) hi = CONT_9F;
    end else begin
      lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
      if (lead == LEAD4_LO) lo = CONT_90;
      if (lead == LEAD4_HI) hi = CONT_8F;
    end
    add_byte(lead);
    add_byte(8'($urandom_range(lo, hi)));
    for (k = 2; k < size; k++) add_byte(8'($urandom_range(CONT_LO, CONT_HI)));
    case (form)
      U8_BAD_CONT:
        name_bytes[$ - $urandom_range(0, size - 2)] =
          8'($urandom_range(0, 1) ? $urandom_range(8'h20, 8'h7F) :
                                    $urandom_range(8'hC0, 8'hFF));
      U8_EDGE_CONT: name_bytes[$ - (size - 2)] = 8'($urandom_range(CONT_LO, CONT_HI));
      U8_TRUNC:     void'(name_bytes.pop_back());
      U8_STRAY:
        add_byte(8'($urandom_range(0, 1) ? $urandom_range(CONT_LO, CONT_HI) :
                                           $urandom_range(8'hF5, 8'hFF)));
      default: ;
    endcase
  endtask

  task automatic put_name(input int n);
    int k;
    logic [7:0] letter;
    for (k = 0; k < n; k++) begin
      letter = 8'($urandom_range(CH_UP_A, CH_UP_Z)) |
               ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
      case ($urandom_range(0, 7))
        0: put_utf8(U8_GOOD);
        1: add_byte((name_bytes.size() == 0 || name_bytes[$] != CH_DOT) ? CH_DOT : letter);
        2: add_byte(CH_SPACE);
        3: add_byte(8'($urandom_range(8'h30, 8'h39)));
        default: add_byte(letter);
      endcase
    end
    if (name_bytes.size() != 0 && (name_bytes[$] == CH_DOT || name_bytes[$] == CH_SPACE) &&
        $urandom_range(0, 3) != 0)
      add_byte(8'h61 + 8'($urandom_range(0, 25)));
  endtask

  task automatic build_component();
    int k;
    shape_t shape;
    logic [23:0] word;
    logic [7:0] ch;
    name_bytes.delete();
    k = $urandom_range(0, 9);
    shape = k < 5 ? SHAPE_NAME : k < 7 ? SHAPE_DEVICE : k < 8 ? SHAPE_FAULT : SHAPE_NOISE;
    case (shape)
      SHAPE_NAME: put_name($urandom_range(1, 10));
      SHAPE_DEVICE: begin
        word = DEVICE_NAMES[$urandom_range(0, 5)];
        for (k = 0; k < 3; k++) begin
          ch = word[23 - 8 * k -: 8];
          if ($urandom_range(0, 1)) ch ^= CASE_BIT;
          add_byte(ch);
        end
        if (word == NAME_COM || word == NAME_LPT || $urandom_range(0, 3) == 0)
          add_byte(8'($urandom_range(8'h30, 8'h39)));
        if ($urandom_range(0, 3) == 0) void'(name_bytes.pop_back());
        if ($urandom_range(0, 1)) begin
          add_byte(CH_DOT);
          put_name($urandom_range(0, 3));
        end
      end
      SHAPE_FAULT: begin
        put_name($urandom_range(0, 6));
        case (fault_t'($urandom_range(0, 3)))
          FAULT_UTF8: put_utf8(utf8_form_t'($urandom_range(1, 4)));
          FAULT_CHAR: begin
            case ($urandom_range(0, 4))
              0: ch = 8'($urandom_range(1, 8'h1F));
              1: ch = CH_DEL;
              2: ch = CH_SLASH;
              3: ch = CH_BSL;
              default: ch = CH_COLON;
            endcase
            add_byte(ch);
          end
          FAULT_DOTS: begin
            add_byte(CH_DOT);
            add_byte(CH_DOT);
          end
          default: begin
            add_byte(8'h00);
            add_byte(8'($urandom_range(0, 255)));
          end
        endcase
        put_name($urandom_range(0, 3));
      end
      default: repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic put_run(input int n);
    name_bytes.delete();
    repeat (n) add_byte(8'h61 + 8'($urandom_range(0, 25)));
  endtask

  task automatic test_directed();
    name_bytes.delete();
    send_component();
    name_bytes = '{8'h61};
    send_component();
    name_bytes = '{8'h43, 8'h6F, 8'h4E};
    send_component();
    name_bytes = '{8'h6C, 8'h50, 8'h74, 8'h39};
    send_component();
    name_bytes = '{8'hC0, 8'hAF};
    send_component();
    name_bytes = '{8'hE2, 8'h82};
    send_component();
    name_bytes = '{8'h61, 8'h62, 8'h00, 8'hFF, CH_SLASH};
    send_component();
    name_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_component();
    name_bytes = '{8'hFF};
    send_component();
    name_bytes = '{8'h61, CH_DOT};
    send_component();
  endtask

  task automatic test_length_limits();
    set_length_cap(8'd0);
    put_run(1);
    send_component();
    set_length_cap(8'd1);
    put_run(1);
    send_component();
    set_length_cap(8'd2);
    put_run(1);
    send_component();
    put_run(2);
    send_component();
    set_length_cap(8'd255);
    put_run(254);
    send_component();
    put_run(256);
    send_component();
    set_length_cap(LENGTH_CAP_RESET);
  endtask

  task automatic test_input_stall();
    hold_requests++;
    repeat (40) begin
      put_run(2);
      send_component();
    end
  endtask

  task automatic test_random();
    int p;
    int goal;
    for (p = 0; p < 6; p++) begin
      set_length_cap(8'(p % 2 == 0 ? $urandom_range(2, 12) : $urandom_range(1, 255)));
      goal = items_sent + 230;
      while (items_sent < goal) begin
        build_component();
        send_component();
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_length_limits();
    test_input_stall();
    test_random();
    await_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
design/pcv_pkg.sv
design/pcv_utf8.sv
design/path_component_validator.sv
dv/path_component_validator_test.sv
